FILE: rtl/wmdef_pkg.sv
// Package for the window mean deviation edge filter.
// Holds the payload types, register indexes, sizes and the size and channel helpers.
// No dependencies.
package wmdef_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CHAN_W    = 8;
    localparam int CHANNELS  = 3;
    localparam int PIX_W     = CHAN_W * CHANNELS;
    localparam int WIN_TAPS  = 9;
    localparam int SUM_W     = 12;
    localparam int WIN_EDGE  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd2;

    localparam int WIDTH_RST     = 640;
    localparam int HEIGHT_RST    = 480;
    localparam int THRESHOLD_RST = 15;
    localparam int SIZE_MIN      = 3;

    // floor(s / 9) equals (s * 3641) >> 15 for every s below 2^15.
    localparam logic [SUM_W-1:0] MEAN_RECIP = 12'd3641;
    localparam int               MEAN_SHIFT = 15;

    localparam logic [CHAN_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [CHAN_W-1:0] EDGE_OFF = 8'd0;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
        logic              frame_start;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0] red_edge;
        logic [CHAN_W-1:0] green_edge;
        logic [CHAN_W-1:0] blue_edge;
        logic              frame_last;
    } t_out_item;

    function automatic logic [CFG_W-1:0] clamp_size(logic [CFG_W-1:0] v, logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] res;
        res = v;
        if (v < CFG_W'(SIZE_MIN)) begin
            res = CFG_W'(SIZE_MIN);
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

    // Channel 0 is red in the top byte, channel 2 is blue in the bottom byte.
    function automatic logic [CHAN_W-1:0] chan_of(logic [PIX_W-1:0] px, int ch);
        return px[CHAN_W*(CHANNELS-1-ch) +: CHAN_W];
    endfunction

endpackage

FILE: rtl/window_mean_deviation_edge_filter.sv
// Top level of the 3x3 window mean deviation edge filter.
// Depends on wmdef_pkg and wmdef_ram.
//
// Usage: RGB pixels enter in raster order on the input channel, one transaction
// per pixel, with frame_start set on the first pixel of a frame. For every pixel
// at row 2 or below and column 2 or beyond, one result transaction leaves on the
// output channel for the window centred one row up and one column to the left.
// Each channel of the result is 255 when any of its nine window values differs
// from their truncated mean by more than the threshold, and 0 otherwise.
// frame_last marks the result of the last pixel of the frame.
// Throughput is one pixel per clock; it is set by the single line memory, which
// is read and written once per pixel. Results are registered in each pipeline
// stage and in the output register. Configuration writes are always taken and
// must only be issued while the block is idle. Reset clears the position
// counters and the window; the line memory holds no reset and needs no clearing
// pass. When the receiver stalls, one further result is held in a skid register,
// after which the input channel is stalled until the output drains.
module window_mean_deviation_edge_filter
    import wmdef_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CW     = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int RW     = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;
    localparam int WLIM   = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
    localparam int HLIM   = (MAX_HEIGHT > 2047) ? 2047 : MAX_HEIGHT;
    localparam int W_RST  = (WIDTH_RST > WLIM) ? WLIM : WIDTH_RST;
    localparam int H_RST  = (HEIGHT_RST > HLIM) ? HLIM : HEIGHT_RST;
    localparam int ENTRY_W = 2 * PIX_W;

    // Configuration
    logic [CFG_W-1:0]  r_width;
    logic [CFG_W-1:0]  r_height;
    logic [CHAN_W-1:0] r_thresh;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(W_RST);
            r_height <= CFG_W'(H_RST);
            r_thresh <= CHAN_W'(THRESHOLD_RST);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    r_width <= clamp_size(i_cfg_data, CFG_W'(WLIM));
                end
                CFG_IMAGE_HEIGHT: begin
                    r_height <= clamp_size(i_cfg_data, CFG_W'(HLIM));
                end
                CFG_THRESHOLD: begin
                    r_thresh <= i_cfg_data[CHAN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Flow control
    logic r_skid_valid;
    logic en;
    logic in_accept;

    assign en         = !r_skid_valid;
    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && en;

    // Position tracking
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] c0;
    logic [ROW_W-1:0] r0;
    logic [CW-1:0]    c_inc;
    logic [RW-1:0]    r_inc;
    logic             col_wrap;
    logic             row_wrap;
    logic             produce0;
    logic             last0;

    always_comb begin
        c0       = i_in_data.frame_start ? '0 : r_col;
        r0       = i_in_data.frame_start ? '0 : r_row;
        c_inc    = CW'(c0) + CW'(1);
        r_inc    = RW'(r0) + RW'(1);
        col_wrap = c_inc >= CW'(r_width);
        row_wrap = r_inc >= RW'(r_height);
        produce0 = (CW'(c0) >= CW'(WIN_EDGE)) && (RW'(r0) >= RW'(WIN_EDGE));
        last0    = (CW'(c0) == CW'(r_width) - CW'(1))
                && (RW'(r0) == RW'(r_height) - RW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (col_wrap) begin
                r_col <= '0;
                r_row <= row_wrap ? '0 : r_inc[ROW_W-1:0];
            end else begin
                r_col <= c_inc[COL_W-1:0];
                r_row <= r0;
            end
        end
    end

    // Line memory: upper row in the top half of an entry, middle row below.
    logic               r_s1_valid;
    logic [COL_W-1:0]   r_s1_addr;
    logic [PIX_W-1:0]   r_s1_px;
    logic               r_s1_produce;
    logic               r_s1_last;
    logic               r_s1_fwd;
    logic [ENTRY_W-1:0] r_s1_fwd_data;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] s1_entry;
    logic [PIX_W-1:0]   s1_top;
    logic [PIX_W-1:0]   s1_mid;
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [PIX_W-1:0]   px0;

    assign px0       = {i_in_data.red_in, i_in_data.green_in, i_in_data.blue_in};
    assign s1_entry  = r_s1_fwd ? r_s1_fwd_data : ram_rdata;
    assign s1_top    = s1_entry[ENTRY_W-1:PIX_W];
    assign s1_mid    = s1_entry[PIX_W-1:0];
    assign ram_we    = en && r_s1_valid;
    assign ram_wdata = {s1_mid, r_s1_px};

    wmdef_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_addr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (c0),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_addr     <= c0;
            r_s1_px       <= px0;
            r_s1_produce  <= produce0;
            r_s1_last     <= last0;
            r_s1_fwd      <= ram_we && (r_s1_addr == c0);
            r_s1_fwd_data <= ram_wdata;
        end
    end

    // Window and arithmetic pipeline
    logic [PIX_W-1:0]  r_win_col [6];
    logic              r_s2_valid;
    logic              r_s2_last;
    logic [PIX_W-1:0]  r_s2_win [WIN_TAPS];
    logic              r_s3_valid;
    logic              r_s3_last;
    logic [PIX_W-1:0]  r_s3_win [WIN_TAPS];
    logic [SUM_W-1:0]  r_s3_sum [CHANNELS];
    logic              r_s4_valid;
    logic              r_s4_last;
    logic [PIX_W-1:0]  r_s4_win [WIN_TAPS];
    logic [CHAN_W-1:0] r_s4_mean [CHANNELS];
    logic [SUM_W-1:0]  sum2 [CHANNELS];
    logic [2*SUM_W-1:0] prod3 [CHANNELS];
    logic [CHANNELS-1:0] edge4;
    t_out_item         res;
    logic              res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_win_col[i] <= '0;
            end
        end else if (en) begin
            r_s1_valid <= i_in_valid;
            r_s2_valid <= r_s1_valid && r_s1_produce;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            if (r_s1_valid) begin
                for (int i = 0; i < 3; i++) begin
                    r_win_col[i] <= r_win_col[i+3];
                end
                r_win_col[3] <= s1_top;
                r_win_col[4] <= s1_mid;
                r_win_col[5] <= r_s1_px;
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            sum2[ch] = '0;
            for (int i = 0; i < WIN_TAPS; i++) begin
                sum2[ch] = sum2[ch] + SUM_W'(chan_of(r_s2_win[i], ch));
            end
            prod3[ch] = r_s3_sum[ch] * MEAN_RECIP;
        end
    end

    always_comb begin
        logic [CHAN_W-1:0] v;
        logic [CHAN_W-1:0] d;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            edge4[ch] = 1'b0;
            for (int i = 0; i < WIN_TAPS; i++) begin
                v = chan_of(r_s4_win[i], ch);
                d = (v > r_s4_mean[ch]) ? v - r_s4_mean[ch] : r_s4_mean[ch] - v;
                if (d > r_thresh) begin
                    edge4[ch] = 1'b1;
                end
            end
        end
        res.red_edge   = edge4[0] ? EDGE_ON : EDGE_OFF;
        res.green_edge = edge4[1] ? EDGE_ON : EDGE_OFF;
        res.blue_edge  = edge4[2] ? EDGE_ON : EDGE_OFF;
        res.frame_last = r_s4_last;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                r_s2_win[i] <= r_win_col[i];
            end
            r_s2_win[6] <= s1_top;
            r_s2_win[7] <= s1_mid;
            r_s2_win[8] <= r_s1_px;
            r_s2_last   <= r_s1_last;
            r_s3_win    <= r_s2_win;
            r_s3_sum    <= sum2;
            r_s3_last   <= r_s2_last;
            r_s4_win    <= r_s3_win;
            r_s4_last   <= r_s3_last;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r_s4_mean[ch] <= prod3[ch][MEAN_SHIFT +: CHAN_W];
            end
        end
    end

    // Output register and skid
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item r_skid;
    logic      out_taken;

    assign res_valid   = en && r_s4_valid;
    assign out_taken   = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_taken) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out        <= res;
                r_out_valid  <= res_valid;
            end
        end else if (res_valid) begin
            r_skid       <= res;
            r_skid_valid <= 1'b1;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_out_stall))
        else $error("skid register filled without a stalled output");

    a_frame_start_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.frame_start) |=> (r_col == COL_W'(1) && r_row == '0))
        else $error("position after a frame start transaction is not row 0, column 1");

    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s4_valid && !en) |=> r_s4_valid)
        else $error("result lost in the last stage while the pipeline was held");

endmodule

FILE: rtl/wmdef_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module wmdef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
